// ===== rtl/core/hsil_pkg.sv =====
// ----------------------------------------------------------------------------
// hsil_pkg
// shared types and defaults for the hash set insert/lookup block
// ----------------------------------------------------------------------------
package hsil_pkg;

  // default geometry
  localparam int unsigned BucketsDefault = 4096;
  localparam int unsigned WaysDefault    = 4;
  localparam int unsigned KeyW           = 32;
  localparam int unsigned QueueDepth     = 2;

  // request kind
  typedef enum logic [0:0] {
    KindLookup = 1'b0,
    KindInsert = 1'b1
  } kind_e;

  // request payload
  typedef struct packed {
    kind_e                    kind;
    logic signed [KeyW-1:0]   key;
  } req_t;

  // response payload
  typedef struct packed {
    logic answer;
    logic bucket_full;
  } rsp_t;

  // back end status towards the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } bstat_t;

  localparam int unsigned ReqW = $bits(req_t);
  localparam int unsigned RspW = $bits(rsp_t);

endpackage

// ===== rtl/core/hsil_ram.sv =====
// ----------------------------------------------------------------------------
// hsil_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module hsil_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hsil_fifo.sv =====
// ----------------------------------------------------------------------------
// hsil_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module hsil_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = hsil_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/hsil_front.sv =====
// ----------------------------------------------------------------------------
// hsil_front
// takes requests and works out the bucket index, key modulo bucket count
// ----------------------------------------------------------------------------
module hsil_front #(
  parameter int unsigned BUCKETS = hsil_pkg::BucketsDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  hsil_pkg::req_t                             req_i,
  output logic                                       ready_o,
  output logic                                       wpush_o,
  output logic [hsil_pkg::ReqW+$clog2(BUCKETS)-1:0]  wdata_o,
  input  logic                                       wfull_i
);

  localparam int unsigned IdxW  = $clog2(BUCKETS);
  localparam int unsigned Shift = hsil_pkg::KeyW + IdxW;
  localparam int unsigned ProdW = 2 * hsil_pkg::KeyW + 1;
  localparam int unsigned QuoW  = ProdW - Shift;
  // floor(2^Shift / BUCKETS), quotient estimate is exact or one low
  localparam longint unsigned RecipL = (64'd1 << Shift) / BUCKETS;
  localparam logic [hsil_pkg::KeyW:0] Recip = (hsil_pkg::KeyW + 1)'(RecipL);
  localparam logic [IdxW:0] BucketsW = (IdxW + 1)'(BUCKETS);

  logic                 v1_q, v2_q;
  hsil_pkg::req_t       req1_q, req2_q;
  logic [QuoW-1:0]      quo1_q;
  logic [IdxW:0]        qb2_q;
  logic [ProdW-1:0]     prod;
  logic [IdxW:0]        rem_raw, rem_fix;
  logic                 adv2;

  // stage 1: reciprocal multiply, key taken as unsigned
  assign prod = ProdW'($unsigned(req_i.key)) * ProdW'(Recip);

  assign adv2    = !v2_q || !wfull_i;
  assign ready_o = !v1_q || adv2;
  assign wpush_o = v2_q && !wfull_i;

  // stage 3 (combinational): remainder and one correction step
  assign rem_raw = req2_q.key[IdxW:0] - qb2_q;
  assign rem_fix = (rem_raw >= BucketsW) ? rem_raw - BucketsW : rem_raw;
  assign wdata_o = {req2_q, rem_fix[IdxW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v1_q <= valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req1_q <= req_i;
      quo1_q <= prod[ProdW-1:Shift];
    end
    if (adv2 && v1_q) begin
      req2_q <= req1_q;
      // only the low bits of quotient times count matter
      qb2_q  <= quo1_q[IdxW:0] * BucketsW;
    end
  end

endmodule

// ===== rtl/core/hsil_back.sv =====
// ----------------------------------------------------------------------------
// hsil_back
// bucket read, way compare and write back, plus the valid clearing pass
// ----------------------------------------------------------------------------
module hsil_back #(
  parameter int unsigned BUCKETS = hsil_pkg::BucketsDefault,
  parameter int unsigned WAYS    = hsil_pkg::WaysDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       wempty_i,
  input  logic [hsil_pkg::ReqW+$clog2(BUCKETS)-1:0]  wdata_i,
  output logic                                       wpop_o,
  input  logic                                       rfull_i,
  output logic                                       rpush_o,
  output hsil_pkg::rsp_t                             rsp_o,
  output hsil_pkg::bstat_t                           status_o
);

  localparam int unsigned IdxW = $clog2(BUCKETS);
  localparam int unsigned KeyW = hsil_pkg::KeyW;
  localparam int unsigned RowW = KeyW * WAYS;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  hsil_pkg::req_t    cur_q;
  logic [IdxW-1:0]   bkt_q;

  hsil_pkg::req_t    head_req;
  logic [IdxW-1:0]   head_bkt;
  logic              issue, look, clearing;

  logic [WAYS-1:0]   vrd, match, free_oh;
  logic [RowW-1:0]   krd, kwr;
  logic              hit, full, ins, do_write;

  logic              v_we;
  logic [IdxW-1:0]   v_waddr;
  logic [WAYS-1:0]   v_wdata;

  assign head_req = hsil_pkg::req_t'(wdata_i[IdxW +: hsil_pkg::ReqW]);
  assign head_bkt = wdata_i[IdxW-1:0];

  assign clearing = (state_q == StClear);
  assign look     = (state_q == StLook);
  assign issue    = (state_q == StIdle) && !wempty_i && !rfull_i;
  assign wpop_o   = issue;

  // parallel compare over the ways of the bucket
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vrd[w] && (krd[w*KeyW +: KeyW] == KeyW'(cur_q.key));
      kwr[w*KeyW +: KeyW] = free_oh[w] ? KeyW'(cur_q.key) : krd[w*KeyW +: KeyW];
    end
  end

  // lowest free way as one-hot
  assign free_oh  = ~vrd & (vrd + 1'b1);
  assign hit      = |match;
  assign full     = ~|free_oh;
  assign ins      = (cur_q.kind == hsil_pkg::KindInsert);
  assign do_write = look && ins && !hit && !full;

  assign rpush_o           = look;
  assign rsp_o.answer      = ins ? (!hit && !full) : hit;
  assign rsp_o.bucket_full = ins && !hit && full;

  assign status_o.clearing = clearing;
  assign status_o.busy     = look;

  assign v_we    = clearing || do_write;
  assign v_waddr = clearing ? clr_q : bkt_q;
  assign v_wdata = clearing ? '0 : (vrd | free_oh);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(BUCKETS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (issue) begin
          state_d = StLook;
        end
      end
      StLook: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cur_q <= head_req;
      bkt_q <= head_bkt;
    end
  end

  hsil_ram #(
    .Width (WAYS),
    .Depth (BUCKETS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (issue),
    .raddr_i (head_bkt),
    .rdata_o (vrd)
  );

  hsil_ram #(
    .Width (RowW),
    .Depth (BUCKETS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (bkt_q),
    .wdata_i (kwr),
    .re_i    (issue),
    .raddr_i (head_bkt),
    .rdata_o (krd)
  );

endmodule

// ===== rtl/core/hash_set_insert_lookup.sv =====
// ----------------------------------------------------------------------------
// hash_set_insert_lookup
// hash set of 32-bit keys with lookup and insert-if-absent requests
// ----------------------------------------------------------------------------
// Each request names a key and a kind (lookup or insert). The bucket is the
// key, read as unsigned, modulo BUCKETS; every bucket holds WAYS keys. A
// lookup answers 1 when the key is stored. An insert answers 1 when it
// stored the key in the lowest free way, 0 when the key was already there,
// and raises bucket_full with answer 0 when the bucket has no free way; keys
// are never evicted. Exactly one response leaves per request, in request
// order. After reset the block clears the valid bits of all buckets, one
// bucket per cycle, and full stays high while that pass runs, so no
// request is taken before it ends. In the front part a request goes
// through the reciprocal multiply, the quotient times bucket count (both
// registered) and the remainder correction. The back part does the
// registered read of the bucket row, then the compare across all ways and
// the write back, and takes no new request before that write back is done.
// ----------------------------------------------------------------------------
module hash_set_insert_lookup #(
  parameter int unsigned BUCKETS = hsil_pkg::BucketsDefault,
  parameter int unsigned WAYS    = hsil_pkg::WaysDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // request side
  input  logic           push,
  input  hsil_pkg::req_t req_i,
  output logic           full,
  // response side
  output logic           empty,
  input  logic           pop,
  output hsil_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW  = $clog2(BUCKETS);
  localparam int unsigned WorkW = hsil_pkg::ReqW + IdxW;

  // front to queue
  logic             front_ready;
  logic             front_valid;
  logic             wpush;
  logic [WorkW-1:0] wdata_in;
  logic             wfull;

  // queue to back
  logic             wpop;
  logic [WorkW-1:0] wdata_out;
  logic             wempty;

  // back to response queue
  logic             rpush;
  hsil_pkg::rsp_t   rsp_back;
  logic             rfull;
  logic [hsil_pkg::RspW-1:0] rsp_raw;

  hsil_pkg::bstat_t bstat;

  // no requests taken while the clearing pass runs
  assign full        = bstat.clearing || !front_ready;
  assign front_valid = push && !full;

  hsil_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .req_i   (req_i),
    .ready_o (front_ready),
    .wpush_o (wpush),
    .wdata_o (wdata_in),
    .wfull_i (wfull)
  );

  // decoupling queue, request plus bucket index
  hsil_fifo #(
    .Width (WorkW),
    .Depth (hsil_pkg::QueueDepth)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wpush),
    .data_i  (wdata_in),
    .full_o  (wfull),
    .pop_i   (wpop),
    .data_o  (wdata_out),
    .empty_o (wempty)
  );

  hsil_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wempty_i (wempty),
    .wdata_i  (wdata_out),
    .wpop_o   (wpop),
    .rfull_i  (rfull),
    .rpush_o  (rpush),
    .rsp_o    (rsp_back),
    .status_o (bstat)
  );

  // response queue lets the back part run on while the consumer stalls, until it fills
  hsil_fifo #(
    .Width (hsil_pkg::RspW),
    .Depth (hsil_pkg::QueueDepth)
  ) u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rpush),
    .data_i  (rsp_back),
    .full_o  (rfull),
    .pop_i   (pop),
    .data_o  (rsp_raw),
    .empty_o (empty)
  );

  assign rsp_o = hsil_pkg::rsp_t'(rsp_raw);

  // a response is only produced when the back part saw room for it
  a_rsp_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpush |-> !rfull)
    else $error("response pushed into a full queue");

  // the bucket index from the front always lies inside the table
  a_bucket_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpush |-> (wdata_in[IdxW-1:0] <= IdxW'(BUCKETS - 1)))
    else $error("bucket index out of range");

  // nothing is looked up before the valid bits are cleared
  a_no_issue_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.clearing |-> (!wpop && !bstat.busy))
    else $error("bucket read during clearing pass");

  // a full bucket never goes with a successful answer
  a_rsp_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpush |-> !(rsp_back.answer && rsp_back.bucket_full))
    else $error("answer and bucket_full both set");

endmodule
